// ----- rtl/core/shtpc_pkg.sv -----
// shared types and constants of the shutter time position controller
package shtpc_pkg;

    localparam int unsigned PADDR_W = 4;

    localparam logic [13:0] FULL_POS     = 14'd10000;
    localparam logic [13:0] PCT_SCALE    = 14'd100;
    localparam logic [13:0] NEAR_LIMIT   = 14'd100;
    localparam logic [13:0] CLOSED_EDGE  = 14'd9800;
    localparam logic [13:0] OPENED_EDGE  = 14'd200;
    localparam logic [6:0]  PCT_MAX      = 7'd100;
    localparam logic [6:0]  TGT_CLOSED   = 7'd98;
    localparam logic [6:0]  TGT_OPENED   = 7'd2;
    localparam logic [16:0] ELAPSED_MAX  = 17'h1FFFF;
    localparam logic [12:0] PCT_RECIP    = 13'd5243;
    localparam int unsigned PCT_SHIFT    = 19;
    localparam logic [4:0]  DIV_LAST     = 5'd30;

    localparam logic [15:0] UP_TRAVEL_RST   = 16'd22000;
    localparam logic [15:0] DOWN_TRAVEL_RST = 16'd19000;
    localparam logic [15:0] REPORT_RST      = 16'd400;

    localparam logic [1:0] REG_UP_TRAVEL   = 2'd0;
    localparam logic [1:0] REG_DOWN_TRAVEL = 2'd1;
    localparam logic [1:0] REG_REPORT      = 2'd2;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_OPEN  = 3'd1,
        CMD_CLOSE = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_SET   = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_STOPPED = 3'd1,
        EV_CLOSED  = 3'd2,
        EV_OPENED  = 3'd3,
        EV_REACHED = 3'd4,
        EV_CLOSING = 3'd5,
        EV_OPENING = 3'd6
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0] command;
        logic [6:0] target_percent;
    } cmd_beat_t;

    typedef struct packed {
        logic       raise_drive;
        logic       lower_drive;
        logic [6:0] position_percent;
        logic [2:0] event_res;
        logic       report_due;
    } res_beat_t;

endpackage

// ----- rtl/core/shutter_time_position_controller_core.sv -----
// top level of the shutter time position controller
// Each command beat yields exactly one result beat. Open, close, stop, set target, unknown codes
// and ticks while the shutter is at rest go from acceptance through the done state to the result
// register. A tick while the shutter moves passes the load, divide, finish and done states: the
// travelled distance elapsed*10000/travel is found by a bit-serial restoring divider that
// produces one of its 31 quotient bits per cycle. A new beat is accepted only once the
// previous result has entered the output register, which holds it while the sink stalls.
module shutter_time_position_controller_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  shtpc_pkg::cmd_beat_t               cmd_data,
    output logic                               res_valid,
    input  logic                               res_stall,
    output shtpc_pkg::res_beat_t               res_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [shtpc_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import shtpc_pkg::*;

    state_t      state_reg, state_next;
    logic [4:0]  count_reg, count_next;
    logic [30:0] num_reg, num_next;
    logic [16:0] rem_reg, rem_next;

    logic [15:0] up_travel_reg, down_travel_reg, report_int_reg;

    logic [13:0] position_reg, position_next;
    logic [13:0] start_reg, start_next;
    logic [6:0]  target_reg, target_next;
    logic        moving_reg, moving_next;
    logic        going_down_reg, going_down_next;
    logic [16:0] elapsed_reg, elapsed_next;
    logic [31:0] tick_count_reg, tick_count_next;
    logic [31:0] last_report_reg, last_report_next;
    event_t      ev_reg, ev_next;
    logic        report_reg, report_next;
    logic        out_valid_reg, out_valid_next;
    res_beat_t   out_reg, out_next;

    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] divisor;
    logic [16:0] div_ext;
    logic [16:0] rem_shift;
    logic        q_bit;
    logic [6:0]  tgt_sel;
    logic [13:0] tpos_cmd;
    logic [13:0] tpos_cur;
    logic [13:0] pos_gap;
    logic [13:0] dtrav;
    logic [14:0] p_down;
    logic [13:0] p_up;
    logic [31:0] since_report;
    logic [26:0] pct_prod;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_comb
    begin
        case (cfg_index)
            REG_UP_TRAVEL:   prdata = {16'd0, up_travel_reg};
            REG_DOWN_TRAVEL: prdata = {16'd0, down_travel_reg};
            REG_REPORT:      prdata = {16'd0, report_int_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_travel_reg   <= UP_TRAVEL_RST;
            down_travel_reg <= DOWN_TRAVEL_RST;
            report_int_reg  <= REPORT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_UP_TRAVEL:   up_travel_reg   <= pwdata[15:0];
                REG_DOWN_TRAVEL: down_travel_reg <= pwdata[15:0];
                REG_REPORT:      report_int_reg  <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // handshake
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    // divider step
    always_comb
    begin
        divisor = going_down_reg ? down_travel_reg : up_travel_reg;
        if (divisor == 16'd0)
        begin
            divisor = 16'd1;
        end
    end
    assign div_ext   = {1'b0, divisor};
    assign rem_shift = {rem_reg[15:0], num_reg[30]};
    assign q_bit     = (rem_shift >= div_ext);

    // target handling for commands
    always_comb
    begin
        case (cmd_data.command)
            CMD_OPEN:  tgt_sel = 7'd0;
            CMD_CLOSE: tgt_sel = PCT_MAX;
            default:   tgt_sel = (cmd_data.target_percent > PCT_MAX) ? PCT_MAX
                                                                      : cmd_data.target_percent;
        endcase
    end
    assign tpos_cmd = 14'(tgt_sel) * PCT_SCALE;
    assign pos_gap  = (tpos_cmd > position_reg) ? (tpos_cmd - position_reg)
                                                : (position_reg - tpos_cmd);

    // movement update after division
    assign tpos_cur     = 14'(target_reg) * PCT_SCALE;
    assign dtrav        = (num_reg > 31'(FULL_POS)) ? FULL_POS : num_reg[13:0];
    assign p_down       = 15'(start_reg) + 15'(dtrav);
    assign p_up         = start_reg - dtrav;
    assign since_report = tick_count_reg - last_report_reg;

    // whole percent of position, x/100 as (x*5243)>>19
    assign pct_prod = 27'(position_reg) * 27'(PCT_RECIP);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        position_next    = position_reg;
        start_next       = start_reg;
        target_next      = target_reg;
        moving_next      = moving_reg;
        going_down_next  = going_down_reg;
        elapsed_next     = elapsed_reg;
        tick_count_next  = tick_count_reg;
        last_report_next = last_report_reg;
        ev_next          = ev_reg;
        report_next      = report_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;

        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ev_next     = EV_NONE;
                    report_next = 1'b0;
                    state_next  = ST_DONE;
                    case (cmd_data.command)
                        CMD_TICK:
                        begin
                            tick_count_next = tick_count_reg + 32'd1;
                            if (moving_reg)
                            begin
                                if (elapsed_reg != ELAPSED_MAX)
                                begin
                                    elapsed_next = elapsed_reg + 17'd1;
                                end
                                state_next = ST_LOAD;
                            end
                        end
                        CMD_OPEN, CMD_CLOSE, CMD_SET:
                        begin
                            if (pos_gap < NEAR_LIMIT)
                            begin
                                if (position_reg >= CLOSED_EDGE)
                                begin
                                    ev_next = EV_CLOSED;
                                end
                                else if (position_reg <= OPENED_EDGE)
                                begin
                                    ev_next = EV_OPENED;
                                end
                                else
                                begin
                                    ev_next = EV_REACHED;
                                end
                                moving_next     = 1'b0;
                                going_down_next = 1'b0;
                                target_next     = 7'd0;
                            end
                            else
                            begin
                                target_next     = tgt_sel;
                                going_down_next = (tpos_cmd > position_reg);
                                moving_next     = 1'b1;
                                elapsed_next    = 17'd0;
                                start_next      = position_reg;
                                ev_next         = (tpos_cmd > position_reg) ? EV_CLOSING
                                                                            : EV_OPENING;
                            end
                        end
                        CMD_STOP:
                        begin
                            moving_next     = 1'b0;
                            going_down_next = 1'b0;
                            target_next     = 7'd0;
                            ev_next         = EV_STOPPED;
                        end
                        default:
                        begin
                            ev_next = EV_NONE;
                        end
                    endcase
                end
            end

            ST_LOAD:
            begin
                num_next   = 31'(31'(elapsed_reg) * 31'(FULL_POS));
                rem_next   = 17'd0;
                count_next = DIV_LAST;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                rem_next   = q_bit ? (rem_shift - div_ext) : rem_shift;
                num_next   = {num_reg[29:0], q_bit};
                count_next = count_reg - 5'd1;
                if (count_reg == 5'd0)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (going_down_reg)
                begin
                    if ((p_down >= 15'(tpos_cur)) || (p_down >= 15'(FULL_POS)))
                    begin
                        position_next   = (target_reg >= TGT_CLOSED) ? FULL_POS : tpos_cur;
                        moving_next     = 1'b0;
                        going_down_next = 1'b0;
                        target_next     = 7'd0;
                        ev_next         = EV_CLOSED;
                    end
                    else
                    begin
                        position_next = p_down[13:0];
                    end
                end
                else
                begin
                    if ((dtrav >= start_reg) || (p_up <= tpos_cur))
                    begin
                        position_next   = (target_reg <= TGT_OPENED) ? 14'd0 : tpos_cur;
                        moving_next     = 1'b0;
                        going_down_next = 1'b0;
                        target_next     = 7'd0;
                        ev_next         = EV_OPENED;
                    end
                    else
                    begin
                        position_next = p_up;
                    end
                end
                if (since_report > 32'(report_int_reg))
                begin
                    last_report_next = tick_count_reg;
                    report_next      = 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    out_next.raise_drive      = moving_reg && !going_down_reg;
                    out_next.lower_drive      = moving_reg && going_down_reg;
                    out_next.position_percent = pct_prod[PCT_SHIFT+6:PCT_SHIFT];
                    out_next.event_res        = ev_reg;
                    out_next.report_due       = report_reg;
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= 5'd0;
            position_reg    <= 14'd0;
            start_reg       <= 14'd0;
            target_reg      <= 7'd0;
            moving_reg      <= 1'b0;
            going_down_reg  <= 1'b0;
            elapsed_reg     <= 17'd0;
            tick_count_reg  <= 32'd0;
            last_report_reg <= 32'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            position_reg    <= position_next;
            start_reg       <= start_next;
            target_reg      <= target_next;
            moving_reg      <= moving_next;
            going_down_reg  <= going_down_next;
            elapsed_reg     <= elapsed_next;
            tick_count_reg  <= tick_count_next;
            last_report_reg <= last_report_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        ev_reg     <= ev_next;
        report_reg <= report_next;
        out_reg    <= out_next;
    end

`ifndef SYNTHESIS
    // lowering only while the motor runs
    assert property (@(posedge clk) disable iff (!rst_n)
        going_down_reg |-> moving_reg)
    else $error("direction set while motor at rest");

    assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= FULL_POS)
    else $error("position beyond end stop");

    // a beat taken moves the controller out of idle in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg != ST_IDLE))
    else $error("accepted beat not processed");

    // divider runs its full length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && count_reg != 5'd0) |=> (state_reg == ST_DIV))
    else $error("divider left early");

    // result register only overwritten after hand-over
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_stall) |=> (out_valid_reg && $stable(out_reg)))
    else $error("pending result lost");
`endif

endmodule

// ----- tb/tb_shutter_time_position_controller_core.sv -----
// testbench for the shutter time position controller core
module tb_shutter_time_position_controller_core;
    import shtpc_pkg::*;

    localparam int unsigned IDLE_LIMIT    = 1000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned PRINT_CAP     = 50;

    class shutter_tracker;
        int unsigned up_ms;
        int unsigned down_ms;
        int unsigned report_ms;
        int unsigned pos;
        int unsigned start_pos;
        int unsigned tgt;
        int unsigned elapsed;
        int unsigned tick_count;
        int unsigned last_report;
        bit          moving;
        bit          going_down;
        res_beat_t   owed_results[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned ticks;
        int unsigned motions;
        int unsigned ignored;
        int unsigned halts_seen;
        int unsigned reports_seen;

        function void clear();
            up_ms = UP_TRAVEL_RST;
            down_ms = DOWN_TRAVEL_RST;
            report_ms = REPORT_RST;
            pos = 0;
            start_pos = 0;
            tgt = 0;
            elapsed = 0;
            tick_count = 0;
            last_report = 0;
            moving = 1'b0;
            going_down = 1'b0;
            owed_results.delete();
            errors = 0;
            checked = 0;
            ticks = 0;
            motions = 0;
            ignored = 0;
            halts_seen = 0;
            reports_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, int unsigned value);
            case (idx)
                REG_UP_TRAVEL:   up_ms = value & 32'hFFFF;
                REG_DOWN_TRAVEL: down_ms = value & 32'hFFFF;
                REG_REPORT:      report_ms = value & 32'hFFFF;
                default: ;
            endcase
        endfunction

        function void halt();
            moving = 1'b0;
            going_down = 1'b0;
            tgt = 0;
        endfunction

        function int unsigned distance(int unsigned travel_ms);
            longint unsigned span;
            longint unsigned num;
            span = (travel_ms == 0) ? 1 : travel_ms;
            num = elapsed;
            num = (num * FULL_POS) / span;
            return num[31:0];
        endfunction

        function event_t tick(output bit report);
            int unsigned     tpos;
            int unsigned     d;
            longint unsigned p;
            event_t          ev;
            ev = EV_NONE;
            report = 1'b0;
            tpos = tgt * PCT_SCALE;
            tick_count++;
            if (!moving)
                return ev;
            if (elapsed < ELAPSED_MAX)
                elapsed++;
            if (going_down) begin
                d = distance(down_ms);
                p = start_pos;
                p = p + d;
                pos = (p > FULL_POS) ? FULL_POS : p[31:0];
                if (p >= tpos || p >= FULL_POS) begin
                    pos = (tgt >= TGT_CLOSED) ? FULL_POS : tpos;
                    halt();
                    ev = EV_CLOSED;
                end
            end else begin
                d = distance(up_ms);
                pos = (d >= start_pos) ? 0 : start_pos - d;
                if (d >= start_pos || pos <= tpos) begin
                    pos = (tgt <= TGT_OPENED) ? 0 : tpos;
                    halt();
                    ev = EV_OPENED;
                end
            end
            if (tick_count - last_report > report_ms) begin
                last_report = tick_count;
                report = 1'b1;
            end
            return ev;
        endfunction

        function event_t steer(int unsigned pct);
            int unsigned tpos;
            int unsigned diff;
            event_t      ev;
            tgt = (pct > PCT_MAX) ? PCT_MAX : pct;
            tpos = tgt * PCT_SCALE;
            diff = (tpos > pos) ? tpos - pos : pos - tpos;
            if (diff < NEAR_LIMIT) begin
                if (pos >= CLOSED_EDGE)
                    ev = EV_CLOSED;
                else if (pos <= OPENED_EDGE)
                    ev = EV_OPENED;
                else
                    ev = EV_REACHED;
                halt();
                return ev;
            end
            going_down = tpos > pos;
            moving = 1'b1;
            elapsed = 0;
            start_pos = pos;
            return going_down ? EV_CLOSING : EV_OPENING;
        endfunction

        function void note_command(cmd_beat_t beat);
            event_t    ev;
            bit        report;
            res_beat_t want;
            ev = EV_NONE;
            report = 1'b0;
            case (beat.command)
                CMD_TICK:  begin ev = tick(report); ticks++; end
                CMD_OPEN:  begin ev = steer(0); motions++; end
                CMD_CLOSE: begin ev = steer(PCT_MAX); motions++; end
                CMD_STOP:  begin halt(); ev = EV_STOPPED; motions++; end
                CMD_SET:   begin ev = steer(beat.target_percent); motions++; end
                default:   ignored++;
            endcase
            want.raise_drive = moving && !going_down;
            want.lower_drive = moving && going_down;
            want.position_percent = 7'(pos / PCT_SCALE);
            want.event_res = ev;
            want.report_due = report;
            owed_results.push_back(want);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("mismatch: %s", msg);
        endtask

        task check_result(res_beat_t got);
            res_beat_t want;
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = owed_results.pop_front();
            checked++;
            if (got.raise_drive !== want.raise_drive)
                report_mismatch($sformatf("beat %0d raise_drive %b, want %b",
                                          checked, got.raise_drive, want.raise_drive));
            if (got.lower_drive !== want.lower_drive)
                report_mismatch($sformatf("beat %0d lower_drive %b, want %b",
                                          checked, got.lower_drive, want.lower_drive));
            if (got.position_percent !== want.position_percent)
                report_mismatch($sformatf("beat %0d position_percent %0d, want %0d",
                                          checked, got.position_percent,
                                          want.position_percent));
            if (got.event_res !== want.event_res)
                report_mismatch($sformatf("beat %0d event_res %0d, want %0d",
                                          checked, got.event_res, want.event_res));
            if (got.report_due !== want.report_due)
                report_mismatch($sformatf("beat %0d report_due %b, want %b",
                                          checked, got.report_due, want.report_due));
            if (want.report_due)
                reports_seen++;
            if (want.event_res inside {EV_CLOSED, EV_OPENED, EV_REACHED})
                halts_seen++;
        endtask

        task flush_check();
            if (owed_results.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_stall;
    cmd_beat_t            cmd_data = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    res_beat_t            res_data;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    shutter_tracker       sb;
    int unsigned          idle_cycles = 0;
    int unsigned          stall_run = 0;
    bit                   stall_level = 1'b0;
    bit                   stall_enable = 1'b1;
    bit                   gaps_enable = 1'b1;
    int unsigned          burst_left = 0;
    int unsigned          settings = 0;

    shutter_time_position_controller_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_run = $urandom_range(1, 12);
            stall_level = stall_enable && ($urandom_range(0, 2) == 0);
        end
        stall_run--;
        res_stall <= stall_level;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                sb.check_result(res_data);
                idle_cycles = 0;
            end
            else if (cmd_valid && !cmd_stall)
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    task send_cmd(input cmd_beat_t beat);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (gaps_enable && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data <= beat;
        do
            @(posedge clk);
        while (!(cmd_valid && !cmd_stall));
        sb.note_command(beat);
    endtask

    task send_item(input logic [2:0] command, input int unsigned pct);
        cmd_beat_t beat;
        beat.command = command;
        beat.target_percent = 7'(pct);
        send_cmd(beat);
    endtask

    task send_ticks(input int unsigned n);
        repeat (n) send_item(CMD_TICK, $urandom_range(0, 127));
    endtask

    task settle();
        @(negedge clk);
        cmd_valid <= 1'b0;
        burst_left = 0;
        while (sb.owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task reg_write(input logic [1:0] idx, input int unsigned value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(idx, value);
    endtask

    task configure(input int unsigned up, input int unsigned down, input int unsigned rep);
        settle();
        reg_write(REG_UP_TRAVEL, up);
        reg_write(REG_DOWN_TRAVEL, down);
        reg_write(REG_REPORT, rep);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        settings++;
    endtask

    function cmd_beat_t pick_command();
        cmd_beat_t   beat;
        int unsigned r;
        r = $urandom_range(0, 99);
        beat.target_percent = 7'($urandom_range(0, 127));
        if (r < 26)
        begin
            beat.command = CMD_SET;
            beat.target_percent = 7'($urandom_range(0, 100));
        end
        else if (r < 32)
        begin
            // aim at the present position, within one percent
            beat.command = CMD_SET;
            beat.target_percent = 7'(sb.pos / PCT_SCALE + $urandom_range(0, 1));
        end
        else if (r < 38)
            beat.command = CMD_SET;
        else if (r < 52)
            beat.command = CMD_OPEN;
        else if (r < 66)
            beat.command = CMD_CLOSE;
        else if (r < 78)
            beat.command = CMD_STOP;
        else if (r < 88)
            beat.command = 3'($urandom_range(5, 7));
        else
            beat.command = CMD_TICK;
        return beat;
    endfunction

    task random_phase(input int unsigned quota, input int unsigned span);
        int unsigned sent;
        int unsigned n;
        cmd_beat_t   beat;
        sent = 0;
        while (sent < quota)
        begin
            beat = pick_command();
            send_cmd(beat);
            if (beat.command <= CMD_SET)
                sent++;
            n = $urandom_range(0, span);
            send_ticks(n);
            sent += n;
        end
    endtask

    initial
    begin
        int unsigned up;
        int unsigned down;
        sb = new();
        sb.clear();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: idle stop, unknown code, open at the end stop, saturated target
        send_item(CMD_STOP, 0);
        send_item(3'd7, 127);
        send_item(CMD_TICK, 0);
        send_item(CMD_OPEN, 0);
        send_item(CMD_SET, 127);
        send_ticks(2);
        send_item(CMD_STOP, 0);

        configure(10, 8, 2);
        send_item(CMD_CLOSE, 0);
        send_ticks(9);
        send_item(CMD_CLOSE, 0);
        send_item(CMD_SET, 99);
        send_item(CMD_TICK, 0);
        send_item(CMD_SET, 50);
        send_item(CMD_TICK, 0);
        send_item(CMD_STOP, 0);
        send_item(CMD_SET, 89);

        configure(1, 1, 0);
        random_phase(150, 4);

        // zero travel counts as one millisecond
        configure(0, 0, 1);
        random_phase(100, 3);

        configure(65535, 65535, 65535);
        random_phase(120, 60);

        for (int k = 0; k < 4; k++)
        begin
            up = $urandom_range(5, 60);
            down = $urandom_range(5, 60);
            configure(up, down, $urandom_range(1, 25));
            gaps_enable = (k != 1);
            stall_enable = (k != 1);
            random_phase(150, ((up > down) ? up : down) + 15);
        end

        settle();
        sb.flush_check();
        $display("covered %0d ticks, %0d motion commands and %0d unknown codes over %0d settings",
                 sb.ticks, sb.motions, sb.ignored, settings + 1);
        $display("checked %0d result beats: %0d halts at a stop or target, %0d reports",
                 sb.checked, sb.halts_seen, sb.reports_seen);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
